// ----- rtl/mlpq_pkg.sv -----
// shared types, codes and defaults for the multilevel priority queue
// no dependencies; compiled first
`default_nettype none

package mlpq_pkg;

	localparam int LEVELS_DEF      = 8;
	localparam int LEVEL_DEPTH_DEF = 8;

	localparam int LEVEL_W = 3;
	localparam int WORD_W  = 32;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_FULL  = 2'd1,
		ST_DEQ   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PTR,
		BK_DATA
	} back_state_t;

	// classified command
	typedef struct packed {
		logic                is_deq;
		logic                lvl_ok;
		logic [LEVEL_W-1:0]  level;
		logic [WORD_W-1:0]   value;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mlpq_if.sv -----
// request and response channel interfaces
// depends on mlpq_pkg for field widths
`default_nettype none

interface mlpq_req_if;
	import mlpq_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [LEVEL_W-1:0]         level;
	logic signed [WORD_W-1:0]   value;

	modport source (output valid, action, level, value, input ready);
	modport sink   (input valid, action, level, value, output ready);
endinterface

interface mlpq_rsp_if;
	import mlpq_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic signed [WORD_W-1:0]   data_out;
	logic [LEVEL_W-1:0]         served_level;

	modport source (output valid, status, data_out, served_level, input ready);
	modport sink   (input valid, status, data_out, served_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/mlpq_front.sv -----
// front stage: takes request transfers and classifies them into commands
// depends on mlpq_pkg and mlpq_req_if
`default_nettype none

module mlpq_front #(
	parameter int LEVELS = mlpq_pkg::LEVELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	mlpq_req_if.sink          req,
	output mlpq_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  wire logic         cmd_ready
);
	import mlpq_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t cls;

	assign req.ready = !vld_s1 || cmd_ready;

	always_comb begin
		cls.is_deq = (req.action == ACT_DEQ);
		cls.lvl_ok = (int'(req.level) < LEVELS);
		cls.level  = req.level;
		cls.value  = req.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = vld_s1;

endmodule

`default_nettype wire

// ----- rtl/mlpq_cmd_queue.sv -----
// short command queue that decouples front and back
// depends on mlpq_pkg
`default_nettype none

module mlpq_cmd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mlpq_pkg::cmd_t    push_cmd,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output mlpq_pkg::cmd_t         pop_cmd,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);
	import mlpq_pkg::*;

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CMDQ_CW'(CMDQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	function automatic logic [CMDQ_AW-1:0] wrap_inc(input logic [CMDQ_AW-1:0] p);
		if (p == CMDQ_AW'(CMDQ_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mlpq_back.sv -----
// back end: per-level pointer update, slot memory access and result register
// depends on mlpq_pkg and mlpq_rsp_if
`default_nettype none

module mlpq_back #(
	parameter int LEVELS      = mlpq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mlpq_pkg::cmd_t   cmd,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	mlpq_rsp_if.source            rsp
);
	import mlpq_pkg::*;

	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DEP_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	back_state_t state_q, state_d;

	cmd_t               cmd_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               hit_q;
	logic [LEVELS-1:0]  nonempty_q;

	// pointer memories, meaningful only where nonempty_q is set
	logic [CNT_W-1:0]   wc_mem [LEVELS];
	logic [DEP_W-1:0]   rp_mem [LEVELS];
	logic [CNT_W-1:0]   wc_rd_q;
	logic [DEP_W-1:0]   rp_rd_q;

	logic [WORD_W-1:0]  slot_mem [SLOTS];
	logic [WORD_W-1:0]  slot_rd_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [WORD_W-1:0]  out_data_q;
	logic [LEVEL_W-1:0] out_level_q;

	logic               out_free;
	logic               found;
	logic [LVL_W-1:0]   enc_lvl;
	logic [LVL_W-1:0]   lvl_sel;
	logic [CNT_W-1:0]   wc_eff;
	logic [DEP_W-1:0]   rp_eff;
	logic [CNT_W-1:0]   rp_inc;
	logic               enq_ok;

	logic               ptr_re;
	logic               ptr_we;
	logic [CNT_W-1:0]   wc_wdata;
	logic [DEP_W-1:0]   rp_wdata;
	logic               slot_we;
	logic               slot_re;
	logic [DEP_W-1:0]   slot_idx;
	logic [ADDR_W-1:0]  slot_addr;
	logic               ne_set;
	logic               ne_clr;
	logic               res_load;
	status_t            res_status;
	logic [WORD_W-1:0]  res_data;
	logic [LEVEL_W-1:0] res_level;

	assign out_free = !out_valid_q || rsp.ready;

	// highest non-empty level, last match wins
	always_comb begin
		found   = 1'b0;
		enc_lvl = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (nonempty_q[i]) begin
				found   = 1'b1;
				enc_lvl = LVL_W'(i);
			end
		end
	end

	assign lvl_sel   = cmd.is_deq ? enc_lvl : LVL_W'(cmd.level);
	assign wc_eff    = nonempty_q[lvl_q] ? wc_rd_q : '0;
	assign rp_eff    = nonempty_q[lvl_q] ? rp_rd_q : '0;
	assign rp_inc    = CNT_W'(rp_eff) + 1'b1;
	assign enq_ok    = cmd_q.lvl_ok && (wc_eff != CNT_W'(LEVEL_DEPTH));
	assign slot_addr = ADDR_W'(lvl_q) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(slot_idx);

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		ptr_re     = 1'b0;
		ptr_we     = 1'b0;
		wc_wdata   = '0;
		rp_wdata   = '0;
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		slot_idx   = wc_eff[DEP_W-1:0];
		ne_set     = 1'b0;
		ne_clr     = 1'b0;
		res_load   = 1'b0;
		res_status = ST_ENQ;
		res_data   = '0;
		res_level  = '0;
		case (state_q)
			BK_IDLE: begin
				cmd_ready = out_free;
				if (cmd_valid && out_free) begin
					ptr_re  = 1'b1;
					state_d = BK_PTR;
				end
			end
			BK_PTR: begin
				if (!cmd_q.is_deq) begin
					res_load = 1'b1;
					state_d  = BK_IDLE;
					if (enq_ok) begin
						slot_we    = 1'b1;
						ptr_we     = 1'b1;
						wc_wdata   = wc_eff + 1'b1;
						rp_wdata   = rp_eff;
						ne_set     = 1'b1;
						res_status = ST_ENQ;
					end else begin
						res_status = ST_FULL;
					end
				end else if (!hit_q) begin
					res_load   = 1'b1;
					res_status = ST_EMPTY;
					state_d    = BK_IDLE;
				end else begin
					slot_re  = 1'b1;
					slot_idx = rp_eff;
					ptr_we   = 1'b1;
					if (rp_inc == wc_eff) begin
						// level drained: pointers back to zero
						ne_clr = 1'b1;
					end else begin
						wc_wdata = wc_eff;
						rp_wdata = rp_inc[DEP_W-1:0];
					end
					state_d = BK_DATA;
				end
			end
			BK_DATA: begin
				res_load   = 1'b1;
				res_status = ST_DEQ;
				res_data   = slot_rd_q;
				res_level  = LEVEL_W'(lvl_q);
				state_d    = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			nonempty_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ne_set) begin
				nonempty_q[lvl_q] <= 1'b1;
			end else if (ne_clr) begin
				nonempty_q[lvl_q] <= 1'b0;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
			lvl_q <= lvl_sel;
			hit_q <= found;
		end
		if (res_load) begin
			out_status_q <= res_status;
			out_data_q   <= res_data;
			out_level_q  <= res_level;
		end
	end

	always_ff @(posedge clk) begin
		if (ptr_we) begin
			wc_mem[lvl_q] <= wc_wdata;
			rp_mem[lvl_q] <= rp_wdata;
		end
		if (ptr_re) begin
			wc_rd_q <= wc_mem[lvl_sel];
			rp_rd_q <= rp_mem[lvl_sel];
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_addr] <= cmd_q.value;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_addr];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.data_out     = out_data_q;
	assign rsp.served_level = out_level_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded while previous result still pending");

	a_data_after_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DATA) |-> ($past(state_q) == BK_PTR))
		else $error("slot data stage entered without pointer stage");

	a_enq_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_PTR && !cmd_q.is_deq) |=> (state_q == BK_IDLE))
		else $error("enqueue did not finish in pointer stage");

	a_served_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_PTR && cmd_q.is_deq && hit_q) |-> nonempty_q[lvl_q])
		else $error("dequeue selected an empty level");

endmodule

`default_nettype wire

// ----- rtl/multilevel_priority_queue_top.sv -----
// multilevel priority queue: enqueue passes back-end states idle and pointer; dequeue
// passes idle, pointer and data; responses come from the back-end result register
// the back end takes a new command only in idle with its result register free, after
// the pointer read-modify-write and the registered slot memory read are through
// reset: control cleared and every level empty at once, no clearing pass
`default_nettype none

module multilevel_priority_queue_top #(
	parameter int LEVELS      = mlpq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mlpq_req_if.sink      req,
	mlpq_rsp_if.source    rsp
);
	import mlpq_pkg::*;

	// front register stage to command queue
	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;

	// command queue to back end
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	// front: takes request transfers, flags out-of-range levels
	mlpq_front #(
		.LEVELS (LEVELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// two-entry queue so request side keeps flowing while the back end works
	mlpq_cmd_queue u_cmd_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// back end: pointer update, slot memory, response register
	mlpq_back #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
